[rtl/ris_pkg.sv]
// ----------------------------------------------------------------------------
// ris_pkg
// Shared codes, field widths and controller/datapath interface types for the
// read interval set block.
// ----------------------------------------------------------------------------
package ris_pkg;

  localparam logic [1:0] CMD_QUERY = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam int CMD_W       = 2;
  localparam int FID_W       = 4;
  localparam int ORD_IN_W    = 16;
  localparam int CNT_OUT_W   = 5;
  localparam int S_TDATA_W   = 24;
  localparam int S_TUSER_W   = 3;
  localparam int M_TDATA_W   = 8;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_QUERY,
    OP_MARK,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_LOW,
    UPD_HIGH,
    UPD_MERGE,
    UPD_INSERT,
    UPD_FULL
  } upd_t;

  typedef struct packed {
    logic take;
    logic clear_all;
    logic cnt_load;
    logic scan;
    logic decide;
    logic shift;
    logic fix;
    logic load_res;
    logic res_zero;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    upd_t upd;
    logic scan_done;
    logic shift_done;
  } dp_stat_t;

endpackage

[rtl/read_interval_set.sv]
// ----------------------------------------------------------------------------
// read_interval_set
// Per-file sorted sets of read command order numbers, kept as run tables.
// ----------------------------------------------------------------------------
// Input stream (s_*): one word per command. Query reports whether the order
// number lies in a run of the file, mark inserts it (extend, join or open a
// run), clear empties every table. Every word gives exactly one result word
// on the output stream (m_*), in order.
// Flow: one word at a time. Clear or a word without a valid file goes from
// dispatch straight to the result. Query loads the count, scans up to the n
// runs held by that file (at most RUNS_PER_FILE) and decides; mark may then
// shift entries and write the fix-up. Scan and shift use one RAM read port,
// one entry per cycle. A new word can be taken the cycle after the result loads.
// The result sits in an output register; a new word is accepted while it
// waits. If the receiver stalls, the next result holds in the controller
// until the register frees up, and no further word is accepted.
// Reset clears the per-file valid bits, so all tables read empty at once;
// no clearing pass over the RAMs is needed.
// ----------------------------------------------------------------------------
module read_interval_set #(
  parameter int FILES         = 16,
  parameter int RUNS_PER_FILE = 16,
  parameter int ORDER_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ris_pkg::S_TDATA_W-1:0] s_tdata,  // file_id[3:0], order[19:4]
  input  logic [ris_pkg::S_TUSER_W-1:0] s_tuser,  // command[1:0], has_file[2]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ris_pkg::M_TDATA_W-1:0] m_tdata   // is_read[0], full_res[1], run_count[6:2]
);
  import ris_pkg::*;

  ctl_cmd_t               cmd;
  dp_stat_t               stat;
  logic [CMD_W-1:0]       command;
  logic [FID_W-1:0]       file_id;
  logic                   has_file;
  logic [ORD_IN_W-1:0]    order;
  logic                   is_read;
  logic                   full_res;
  logic [CNT_OUT_W-1:0]   run_count;

  assign command  = s_tuser[CMD_W-1:0];
  assign has_file = s_tuser[CMD_W];
  assign file_id  = s_tdata[FID_W-1:0];
  assign order    = s_tdata[FID_W+ORD_IN_W-1:FID_W];
  assign m_tdata  = {1'b0, run_count, full_res, is_read};

  ris_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ris_dp #(
    .FILES         (FILES),
    .RUNS_PER_FILE (RUNS_PER_FILE),
    .ORDER_BITS    (ORDER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .command   (command),
    .file_id   (file_id),
    .has_file  (has_file),
    .order     (order),
    .is_read   (is_read),
    .full_res  (full_res),
    .run_count (run_count)
  );

endmodule

[rtl/ris_ram.sv]
// ----------------------------------------------------------------------------
// ris_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ris_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/ris_dp.sv]
// ----------------------------------------------------------------------------
// ris_dp
// Datapath: run tables in RAM, per-file run counts with valid bits, scan
// pointer, shift engine and result register.
// ----------------------------------------------------------------------------
module ris_dp #(
  parameter int FILES         = 16,
  parameter int RUNS_PER_FILE = 16,
  parameter int ORDER_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ris_pkg::ctl_cmd_t              cmd,
  output ris_pkg::dp_stat_t              stat,
  input  logic [ris_pkg::CMD_W-1:0]      command,
  input  logic [ris_pkg::FID_W-1:0]      file_id,
  input  logic                           has_file,
  input  logic [ris_pkg::ORD_IN_W-1:0]   order,
  output logic                           is_read,
  output logic                           full_res,
  output logic [ris_pkg::CNT_OUT_W-1:0]  run_count
);
  import ris_pkg::*;

  localparam int FB = (FILES > 1) ? $clog2(FILES) : 1;
  localparam int AW = (FILES * RUNS_PER_FILE > 1) ? $clog2(FILES * RUNS_PER_FILE) : 1;
  localparam int CW = $clog2(RUNS_PER_FILE + 1);
  localparam int OW = ORDER_BITS;

  logic [CMD_W-1:0] cmd_q;
  logic             has_q;
  logic [FID_W-1:0] fid_q;
  logic [OW-1:0]    ord_q;
  logic [AW-1:0]    base;
  logic [CW-1:0]    n;
  logic [CW-1:0]    n_next;
  logic [CW-1:0]    ptr;
  logic             cval;
  logic             found;
  logic [CW-1:0]    pos;
  logic [OW-1:0]    beg_i;
  logic [OW-1:0]    end_i;
  logic [OW-1:0]    prev_end;
  logic [CW-1:0]    mv_left;
  logic [CW-1:0]    mv_dst;
  logic             mv_pend;
  logic             mv_up;
  logic             res_read;
  logic             res_full;
  logic [FILES-1:0] valid;

  logic [FB-1:0]    fidx;
  logic             file_ok;
  op_t              op;
  upd_t             upd;
  logic             hit;
  logic             join_lo;
  logic             join_hi;
  logic             scan_stop;
  logic             scan_exh;
  logic [OW:0]      ord_inc;
  logic [OW:0]      prev_inc;

  logic [AW-1:0]    rd_addr;
  logic [OW-1:0]    rb_q;
  logic [OW-1:0]    re_q;
  logic             wb_en;
  logic             we_en;
  logic [AW-1:0]    wb_addr;
  logic [AW-1:0]    we_addr;
  logic [OW-1:0]    wb_data;
  logic [OW-1:0]    we_data;
  logic [CW-1:0]    cnt_q;

  assign fidx     = FB'(fid_q);
  assign file_ok  = has_q && (32'(fid_q) < 32'(FILES));
  assign ord_inc  = (OW+1)'(ord_q) + (OW+1)'(1);
  assign prev_inc = (OW+1)'(prev_end) + (OW+1)'(1);
  assign hit      = found && (beg_i <= ord_q);
  assign join_lo  = (pos != '0) && (prev_inc == (OW+1)'(ord_q));
  assign join_hi  = found && ((OW+1)'(beg_i) == ord_inc);
  assign scan_stop = cval && (re_q >= ord_q);
  assign scan_exh  = !cval && (ptr == n);
  assign rd_addr   = base + AW'(ptr);

  always_comb begin
    if (cmd_q == CMD_CLEAR) begin
      op = OP_CLEAR;
    end else if (file_ok && cmd_q == CMD_QUERY) begin
      op = OP_QUERY;
    end else if (file_ok && cmd_q == CMD_MARK) begin
      op = OP_MARK;
    end else begin
      op = OP_NONE;
    end
  end

  always_comb begin
    if (hit) begin
      upd = UPD_NONE;
    end else if (join_lo && join_hi) begin
      upd = UPD_MERGE;
    end else if (join_lo) begin
      upd = UPD_LOW;
    end else if (join_hi) begin
      upd = UPD_HIGH;
    end else if (n >= CW'(RUNS_PER_FILE)) begin
      upd = UPD_FULL;
    end else begin
      upd = UPD_INSERT;
    end
  end

  always_comb begin
    case (upd)
      UPD_MERGE:  n_next = n - CW'(1);
      UPD_INSERT: n_next = n + CW'(1);
      default:    n_next = n;
    endcase
  end

  assign stat.op         = op;
  assign stat.upd        = upd;
  assign stat.scan_done  = scan_stop || scan_exh;
  assign stat.shift_done = (mv_left == '0) && !mv_pend;

  // table write ports: shift moves, then the single fix-up write
  always_comb begin
    wb_en   = 1'b0;
    we_en   = 1'b0;
    wb_addr = base + AW'(mv_dst);
    we_addr = base + AW'(mv_dst);
    wb_data = rb_q;
    we_data = re_q;
    if (cmd.shift && mv_pend) begin
      wb_en = 1'b1;
      we_en = 1'b1;
    end else if (cmd.fix) begin
      case (upd)
        UPD_LOW: begin
          we_en   = 1'b1;
          we_addr = base + AW'(pos) - AW'(1);
          we_data = ord_q;
        end
        UPD_HIGH: begin
          wb_en   = 1'b1;
          wb_addr = base + AW'(pos);
          wb_data = ord_q;
        end
        UPD_MERGE: begin
          we_en   = 1'b1;
          we_addr = base + AW'(pos) - AW'(1);
          we_data = end_i;
        end
        UPD_INSERT: begin
          wb_en   = 1'b1;
          we_en   = 1'b1;
          wb_addr = base + AW'(pos);
          we_addr = base + AW'(pos);
          wb_data = ord_q;
          we_data = ord_q;
        end
        default: begin
        end
      endcase
    end
  end

  ris_ram #(.WIDTH(OW), .DEPTH(FILES * RUNS_PER_FILE)) u_begin_ram (
    .clk     (clk),
    .wr_en   (wb_en),
    .wr_addr (wb_addr),
    .wr_data (wb_data),
    .rd_addr (rd_addr),
    .rd_data (rb_q)
  );

  ris_ram #(.WIDTH(OW), .DEPTH(FILES * RUNS_PER_FILE)) u_end_ram (
    .clk     (clk),
    .wr_en   (we_en),
    .wr_addr (we_addr),
    .wr_data (we_data),
    .rd_addr (rd_addr),
    .rd_data (re_q)
  );

  ris_ram #(.WIDTH(CW), .DEPTH(FILES)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cmd.fix),
    .wr_addr (fidx),
    .wr_data (n_next),
    .rd_addr (fidx),
    .rd_data (cnt_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      mv_pend <= 1'b0;
    end else begin
      if (cmd.clear_all) begin
        valid <= '0;
      end else if (cmd.fix) begin
        valid[fidx] <= 1'b1;
      end
      if (cmd.decide) begin
        mv_pend <= 1'b0;
      end else if (cmd.shift) begin
        mv_pend <= (mv_left != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cmd_q <= command;
      has_q <= has_file;
      fid_q <= file_id;
      ord_q <= OW'(order);
    end
    if (cmd.cnt_load) begin
      base  <= AW'(32'(fidx) * 32'(RUNS_PER_FILE));
      n     <= valid[fidx] ? cnt_q : '0;
      ptr   <= '0;
      cval  <= 1'b0;
      found <= 1'b0;
    end
    if (cmd.scan) begin
      if (scan_stop) begin
        found <= 1'b1;
        pos   <= ptr - CW'(1);
        beg_i <= rb_q;
        end_i <= re_q;
      end else if (scan_exh) begin
        found <= 1'b0;
        pos   <= n;
      end else begin
        if (cval) begin
          prev_end <= re_q;
        end
        if (ptr != n) begin
          cval <= 1'b1;
          ptr  <= ptr + CW'(1);
        end else begin
          cval <= 1'b0;
        end
      end
    end
    if (cmd.decide) begin
      res_read <= hit;
      res_full <= (op == OP_MARK) && (upd == UPD_FULL);
      if (upd == UPD_MERGE) begin
        ptr     <= pos + CW'(1);
        mv_left <= n - pos - CW'(1);
        mv_up   <= 1'b0;
      end else begin
        ptr     <= n - CW'(1);
        mv_left <= n - pos;
        mv_up   <= 1'b1;
      end
    end
    if (cmd.shift && (mv_left != '0)) begin
      mv_dst  <= mv_up ? ptr + CW'(1) : ptr - CW'(1);
      ptr     <= mv_up ? ptr - CW'(1) : ptr + CW'(1);
      mv_left <= mv_left - CW'(1);
    end
    if (cmd.fix) begin
      n <= n_next;
    end
    if (cmd.load_res) begin
      is_read   <= cmd.res_zero ? 1'b0 : res_read;
      full_res  <= cmd.res_zero ? 1'b0 : res_full;
      run_count <= cmd.res_zero ? '0 : CNT_OUT_W'(n);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> n <= CW'(RUNS_PER_FILE))
    else $error("run count above table capacity");

  a_merge_pos: assert property (@(posedge clk) disable iff (rst)
    (cmd.fix && upd == UPD_MERGE) |-> pos != '0)
    else $error("merge without a lower run");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.fix && upd == UPD_INSERT) |-> n < CW'(RUNS_PER_FILE))
    else $error("insert into a full table");

endmodule

[rtl/ris_ctrl.sv]
// ----------------------------------------------------------------------------
// ris_ctrl
// Controller: sequences accept, count lookup, run scan, table update and
// result hand-off; owns the input ready and output valid.
// ----------------------------------------------------------------------------
module ris_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  ris_pkg::dp_stat_t  stat,
  output ris_pkg::ctl_cmd_t  cmd
);
  import ris_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CNT_LD,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_FIX,
    S_DONE
  } state_t;

  state_t state;
  logic   zero_res;
  logic   slot_free;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:     cmd.take      = s_tvalid;
      S_DISPATCH: cmd.clear_all = (stat.op == OP_CLEAR);
      S_CNT_LD:   cmd.cnt_load  = 1'b1;
      S_SCAN:     cmd.scan      = 1'b1;
      S_DECIDE:   cmd.decide    = 1'b1;
      S_SHIFT:    cmd.shift     = 1'b1;
      S_FIX:      cmd.fix       = 1'b1;
      S_DONE: begin
        cmd.load_res = slot_free;
        cmd.res_zero = zero_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      zero_res <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load_res) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (stat.op)
            OP_QUERY, OP_MARK: begin
              zero_res <= 1'b0;
              state    <= S_CNT_LD;
            end
            default: begin
              zero_res <= 1'b1;
              state    <= S_DONE;
            end
          endcase
        end
        S_CNT_LD: state <= S_SCAN;
        S_SCAN: begin
          if (stat.scan_done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (stat.op == OP_QUERY) begin
            state <= S_DONE;
          end else begin
            case (stat.upd)
              UPD_MERGE, UPD_INSERT: state <= S_SHIFT;
              UPD_LOW, UPD_HIGH:     state <= S_FIX;
              default:               state <= S_DONE;
            endcase
          end
        end
        S_SHIFT: begin
          if (stat.shift_done) begin
            state <= S_FIX;
          end
        end
        S_FIX: state <= S_DONE;
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word taken while one is in flight");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.load_res |=> m_tvalid)
    else $error("loaded result not presented");

endmodule
